FILE: hdl/qte_pkg.sv
package qte_pkg;

  // Field widths of the request and result channels.
  localparam int COMP_BITS     = 16;
  localparam int OUT_W         = 16;

  // Internal arithmetic widths: products at 30 fractional bits, terms with
  // room for the doubling, CORDIC datapath with room for the gain.
  localparam int PROD_W        = 32;
  localparam int TERM_W        = 35;
  localparam int T3_W          = 32;
  localparam int CORD_W        = 36;
  localparam int ANG_W         = 32;
  localparam int RAD_W         = 61;
  localparam int ROOT_W        = 31;
  localparam int REM_W         = 62;
  localparam int CORDIC_STAGES = 16;
  localparam int ROOT_STAGES   = ROOT_W;

  // Pipeline stage positions.
  localparam int ST_PROD  = 0;
  localparam int ST_TERM  = 1;
  localparam int ST_SQ    = 2;
  localparam int ST_RAD   = 3;
  localparam int ST_ROOT0 = 4;
  localparam int ST_CORD0 = ST_ROOT0 + ROOT_STAGES;
  localparam int ST_OUT   = ST_CORD0 + CORDIC_STAGES + 1;
  localparam int NUM_ST   = ST_OUT + 1;

  localparam logic signed [TERM_W-1:0] ONE_Q30     = TERM_W'(64'sd1 <<< 30);
  localparam logic [RAD_W-1:0]         ONE_Q60     = RAD_W'(64'd1 << 60);
  localparam logic [ANG_W-1:0]         ANG_QUARTER = 32'h4000_0000;
  localparam logic [ANG_W-1:0]         ANG_HALF_LSB = 32'h0000_8000;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic signed [TERM_W-1:0]    term_t;
  typedef logic signed [CORD_W-1:0]    cord_t;

  typedef struct packed {
    term_t                  t1;
    term_t                  t2;
    term_t                  t4;
    term_t                  t5;
    logic signed [T3_W-1:0] t3;
    logic                   clamped;
  } terms_t;

  // Arctangent of 2^-k in binary angle units, 2^31 equals pi.
  function automatic logic [ANG_W-1:0] atan_entry(input int k);
    logic [ANG_W-1:0] tab [32];
    tab = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
    };
    return tab[k[4:0]];
  endfunction

endpackage

FILE: hdl/qte_quat_if.sv
interface qte_quat_if;
  import qte_pkg::*;

  logic  valid;
  logic  ready;
  comp_t quat_x;
  comp_t quat_y;
  comp_t quat_z;
  comp_t quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

FILE: hdl/qte_euler_if.sv
interface qte_euler_if;
  import qte_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] yaw_angle;
  logic signed [OUT_W-1:0] pitch_angle;
  logic signed [OUT_W-1:0] roll_angle;
  logic                    roll_clamped;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, roll_clamped,
                  input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, roll_clamped,
                  output ready);
endinterface

FILE: hdl/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
  input  logic                   clk_i,
  input  logic [ROOT_STAGES-1:0] en_i,
  input  logic [RAD_W-1:0]       rad_i,
  output logic [ROOT_W-1:0]      root_o
);

  logic [RAD_W-1:0] rem_q [ROOT_STAGES];
  logic [REM_W-1:0] res_q [ROOT_STAGES];

  // One result bit per stage, restoring digit recurrence.
  for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_step
    localparam logic [REM_W-1:0] Bit = REM_W'(1) << (2 * (ROOT_STAGES - 1 - j));
    logic [RAD_W-1:0] rem_in;
    logic [REM_W-1:0] res_in;
    logic [REM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[j] <= rem_in - trial[RAD_W-1:0];
          res_q[j] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[ROOT_STAGES-1][ROOT_W-1:0];

endmodule

FILE: hdl/qte_cordic.sv
module qte_cordic import qte_pkg::*; (
  input  logic                     clk_i,
  input  logic [CORDIC_STAGES:0]   en_i,
  input  cord_t                    y_i,
  input  cord_t                    x_i,
  output logic [ANG_W-1:0]         ang_o
);

  cord_t            x_q    [CORDIC_STAGES+1];
  cord_t            y_q    [CORDIC_STAGES+1];
  logic [ANG_W-1:0] ang_q  [CORDIC_STAGES+1];
  logic             zero_q [CORDIC_STAGES+1];

  // Pre-rotation by a quarter turn brings the vector into the right half plane.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[CORD_W-1]) begin
        if (!y_i[CORD_W-1]) begin
          x_q[0]   <= y_i;
          y_q[0]   <= -x_i;
          ang_q[0] <= ANG_QUARTER;
        end else begin
          x_q[0]   <= -y_i;
          y_q[0]   <= x_i;
          ang_q[0] <= -ANG_QUARTER;
        end
      end else begin
        x_q[0]   <= x_i;
        y_q[0]   <= y_i;
        ang_q[0] <= '0;
      end
    end
  end

  // Vectoring micro-rotations, one per stage, driving y towards zero.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    cord_t dx;
    cord_t dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CORD_W-1]) begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          ang_q[i+1] <= ang_q[i] + atan_entry(i);
        end else begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          ang_q[i+1] <= ang_q[i] - atan_entry(i);
        end
      end
    end
  end

  // A null vector has angle zero by definition.
  assign ang_o = zero_q[CORDIC_STAGES] ? '0 : ang_q[CORDIC_STAGES];

endmodule

FILE: hdl/quat_to_euler_angles_top.sv
// Quaternion to yaw, pitch and roll conversion, fully pipelined.
// Pipeline depth is dominated by the 31-stage square root followed by the
// 17-stage CORDIC.
// Throughput: one request per cycle; each stage holds its item under back-pressure.
// Reset: asynchronous, active low, clears all stage valid bits; no other state.
module quat_to_euler_angles_top import qte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  qte_quat_if.sink    quat_i,
  qte_euler_if.source euler_o
);

  logic [NUM_ST-1:0] vld_q;
  logic [NUM_ST:0]   en;

  // Each stage moves when it is empty or its successor moves.
  always_comb begin
    en[NUM_ST] = euler_o.ready;
    for (int k = NUM_ST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign quat_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= quat_i.valid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Product of two components aligned to Q1.31, kept at 30 fractional bits.
  function automatic logic signed [PROD_W-1:0] mulq(input comp_t a, input comp_t b);
    logic signed [31:0] ax;
    logic signed [31:0] bx;
    logic signed [63:0] p;
    ax = 32'(a) <<< (32 - COMP_BITS);
    bx = 32'(b) <<< (32 - COMP_BITS);
    p  = 64'(ax) * 64'(bx);
    return p[63:32];
  endfunction

  // Stage: the ten component products.
  logic signed [PROD_W-1:0] pxx_q, pyy_q, pzz_q, pww_q, pxy_q;
  logic signed [PROD_W-1:0] pwz_q, pxz_q, pwy_q, pwx_q, pyz_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      pxx_q <= mulq(quat_i.quat_x, quat_i.quat_x);
      pyy_q <= mulq(quat_i.quat_y, quat_i.quat_y);
      pzz_q <= mulq(quat_i.quat_z, quat_i.quat_z);
      pww_q <= mulq(quat_i.quat_w, quat_i.quat_w);
      pxy_q <= mulq(quat_i.quat_x, quat_i.quat_y);
      pwz_q <= mulq(quat_i.quat_w, quat_i.quat_z);
      pxz_q <= mulq(quat_i.quat_x, quat_i.quat_z);
      pwy_q <= mulq(quat_i.quat_w, quat_i.quat_y);
      pwx_q <= mulq(quat_i.quat_w, quat_i.quat_x);
      pyz_q <= mulq(quat_i.quat_y, quat_i.quat_z);
    end
  end

  // Stage: the five atan2 terms, with the asin argument saturated to one.
  terms_t terms_d;
  terms_t term1_q, term2_q, term3_q;
  term_t  t3_raw;

  always_comb begin
    terms_d.t1 = (TERM_W'(pxy_q) + TERM_W'(pwz_q)) <<< 1;
    terms_d.t2 = TERM_W'(pww_q) + TERM_W'(pxx_q) - TERM_W'(pyy_q) - TERM_W'(pzz_q);
    terms_d.t4 = (TERM_W'(pwx_q) + TERM_W'(pyz_q)) <<< 1;
    terms_d.t5 = TERM_W'(pww_q) - TERM_W'(pxx_q) - TERM_W'(pyy_q) + TERM_W'(pzz_q);
    t3_raw     = (TERM_W'(pwy_q) - TERM_W'(pxz_q)) <<< 1;
    if (t3_raw > ONE_Q30) begin
      terms_d.t3      = T3_W'(ONE_Q30);
      terms_d.clamped = 1'b1;
    end else if (t3_raw < -ONE_Q30) begin
      terms_d.t3      = T3_W'(-ONE_Q30);
      terms_d.clamped = 1'b1;
    end else begin
      terms_d.t3      = T3_W'(t3_raw);
      terms_d.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_TERM]) begin
      term1_q <= terms_d;
    end
  end

  // Stage: square of the asin argument.
  logic [ROOT_W-1:0]  t3_mag;
  logic [RAD_W-1:0]   sq_full;
  logic [RAD_W-1:0]   sq_q;
  logic [RAD_W-1:0]   rad_q;

  assign t3_mag  = term1_q.t3[T3_W-1] ? ROOT_W'(-term1_q.t3) : ROOT_W'(term1_q.t3);
  assign sq_full = RAD_W'(t3_mag) * RAD_W'(t3_mag);

  always_ff @(posedge clk_i) begin
    if (en[ST_SQ]) begin
      sq_q    <= sq_full;
      term2_q <= term1_q;
    end
  end

  // Stage: radicand 1 - t^2 at 60 fractional bits.
  always_ff @(posedge clk_i) begin
    if (en[ST_RAD]) begin
      rad_q   <= ONE_Q60 - sq_q;
      term3_q <= term2_q;
    end
  end

  // Square root, with the terms travelling alongside.
  logic [ROOT_W-1:0] root;
  terms_t            dly_q [ROOT_STAGES];

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en[ST_ROOT0 +: ROOT_STAGES]),
    .rad_i  (rad_q),
    .root_o (root)
  );

  for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_dly
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[ST_ROOT0]) begin
          dly_q[0] <= term3_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[ST_ROOT0 + j]) begin
          dly_q[j] <= dly_q[j-1];
        end
      end
    end
  end

  // Three CORDIC angle units in step, the clamp flag delayed to match.
  terms_t           tl;
  logic [ANG_W-1:0] yaw_ang, pitch_ang, roll_ang;
  logic             clamp_q [CORDIC_STAGES+1];

  assign tl = dly_q[ROOT_STAGES-1];

  qte_cordic u_yaw (
    .clk_i (clk_i),
    .en_i  (en[ST_CORD0 +: CORDIC_STAGES + 1]),
    .y_i   (CORD_W'(tl.t1)),
    .x_i   (CORD_W'(tl.t2)),
    .ang_o (yaw_ang)
  );

  qte_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (en[ST_CORD0 +: CORDIC_STAGES + 1]),
    .y_i   (CORD_W'(tl.t4)),
    .x_i   (CORD_W'(tl.t5)),
    .ang_o (pitch_ang)
  );

  qte_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (en[ST_CORD0 +: CORDIC_STAGES + 1]),
    .y_i   (CORD_W'(tl.t3)),
    .x_i   (CORD_W'({1'b0, root})),
    .ang_o (roll_ang)
  );

  for (genvar i = 0; i <= CORDIC_STAGES; i++) begin : g_clamp
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[ST_CORD0]) begin
          clamp_q[0] <= tl.clamped;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[ST_CORD0 + i]) begin
          clamp_q[i] <= clamp_q[i-1];
        end
      end
    end
  end

  // Output register: angles rounded half up to 16 bits.
  logic [ANG_W-1:0] yaw_r, pitch_r, roll_r;
  logic [OUT_W-1:0] yaw_q, pitch_q, roll_q;
  logic             clamped_q;

  assign yaw_r   = yaw_ang + ANG_HALF_LSB;
  assign pitch_r = pitch_ang + ANG_HALF_LSB;
  assign roll_r  = roll_ang + ANG_HALF_LSB;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      yaw_q     <= yaw_r[ANG_W-1 -: OUT_W];
      pitch_q   <= pitch_r[ANG_W-1 -: OUT_W];
      roll_q    <= roll_r[ANG_W-1 -: OUT_W];
      clamped_q <= clamp_q[CORDIC_STAGES];
    end
  end

  assign euler_o.valid        = vld_q[ST_OUT];
  assign euler_o.yaw_angle    = yaw_q;
  assign euler_o.pitch_angle  = pitch_q;
  assign euler_o.roll_angle   = roll_q;
  assign euler_o.roll_clamped = clamped_q;

endmodule

FILE: tb/quat_to_euler_angles_top_tb.sv
`timescale 1ns / 100ps

module quat_to_euler_angles_top_tb;
  import qte_pkg::*;

  localparam int NUM_RANDOM = 1150;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 120;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } euler_t;

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return floor_shr(a * b, 32);
  endfunction

  // Vectoring CORDIC arctangent in 32-bit binary angle units.
  function automatic longint cordic_angle(longint yv, longint xv);
    longint ang;
    longint tmp;
    longint dx;
    longint dy;
    logic [ANG_W-1:0] entry;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        tmp = xv; xv = yv; yv = -tmp; ang = 64'sd1 <<< 30;
      end else begin
        tmp = xv; xv = -yv; yv = tmp; ang = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      entry = atan_entry(i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += longint'(entry);
      end else begin
        xv -= dx; yv += dy; ang -= longint'(entry);
      end
    end
    return ang;
  endfunction

  function automatic logic [15:0] angle_to_16(longint a);
    longint r;
    r = floor_shr(a + 32768, 16);
    return r[15:0];
  endfunction

  // Floor integer square root.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t predict_euler(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
    longint x, y, z, w, sx, sy, sz, sw, t1, t2, t3, t4, t5, c;
    longint one;
    euler_t e;
    one = 64'sd1 <<< 30;
    x = longint'(qx) * 65536;
    y = longint'(qy) * 65536;
    z = longint'(qz) * 65536;
    w = longint'(qw) * 65536;
    sx = mul_q30(x, x); sy = mul_q30(y, y); sz = mul_q30(z, z); sw = mul_q30(w, w);
    t1 = 2 * (mul_q30(x, y) + mul_q30(w, z));
    t2 = sw + sx - sy - sz;
    t3 = -2 * (mul_q30(x, z) - mul_q30(w, y));
    t4 = 2 * (mul_q30(w, x) + mul_q30(y, z));
    t5 = sw - sx - sy + sz;
    e.clamped = 1'b0;
    // The asin argument saturates at plus or minus one.
    if (t3 > one) begin
      t3 = one; e.clamped = 1'b1;
    end else if (t3 < -one) begin
      t3 = -one; e.clamped = 1'b1;
    end
    c = longint'(root_floor((64'd1 << 60) - longint'(t3 * t3)));
    e.yaw = angle_to_16(cordic_angle(t1, t2));
    e.pitch = angle_to_16(cordic_angle(t4, t5));
    e.roll = angle_to_16(cordic_angle(t3, c));
    return e;
  endfunction

  // Holds the predicted angles of requests in flight and checks results.
  class euler_scoreboard;
    euler_t pending[$];
    int     errors;

    function void note_request(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
      pending.push_back(predict_euler(qx, qy, qz, qw));
    endfunction

    function void check_result(euler_t got);
      euler_t exp_e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result yaw %0d pitch %0d roll %0d clamped %0b",
                 $time, got.yaw, got.pitch, got.roll, got.clamped);
        errors++;
        return;
      end
      exp_e = pending.pop_front();
      if (got.yaw !== exp_e.yaw) begin
        $display("%0t: yaw expected %0d actual %0d", $time, exp_e.yaw, got.yaw);
        errors++;
      end
      if (got.pitch !== exp_e.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, exp_e.pitch, got.pitch);
        errors++;
      end
      if (got.roll !== exp_e.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, exp_e.roll, got.roll);
        errors++;
      end
      if (got.clamped !== exp_e.clamped) begin
        $display("%0t: clamp flag expected %0b actual %0b", $time, exp_e.clamped,
                 got.clamped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qte_quat_if  quat_bus ();
  qte_euler_if euler_bus ();

  quat_to_euler_angles_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quat_i  (quat_bus.sink),
    .euler_o (euler_bus.source)
  );

  euler_scoreboard angle_board = new();
  int  idle_cycles = 0;
  int  results_seen = 0;
  int  clamped_seen = 0;
  bit  stall_on = 1'b0;

  always #1 clk_i = ~clk_i;

  initial begin
    quat_bus.valid  = 1'b0;
    quat_bus.quat_x = '0;
    quat_bus.quat_y = '0;
    quat_bus.quat_z = '0;
    quat_bus.quat_w = '0;
    euler_bus.ready = 1'b0;
  end

  // Receiver: alternates between ready stretches and stall stretches.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_on <= ($urandom_range(0, 3) == 0);
      stall_left <= $urandom_range(1, 12);
    end else begin
      stall_left <= stall_left - 1;
    end
    euler_bus.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Results are sampled at the edge on which the handshake completes.
  always @(posedge clk_i) begin
    euler_t got;
    if (rst_ni && euler_bus.valid && euler_bus.ready) begin
      got.yaw = euler_bus.yaw_angle;
      got.pitch = euler_bus.pitch_angle;
      got.roll = euler_bus.roll_angle;
      got.clamped = euler_bus.roll_clamped;
      angle_board.check_result(got);
      results_seen++;
      if (got.clamped === 1'b1) clamped_seen++;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((quat_bus.valid && quat_bus.ready) || (euler_bus.valid && euler_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("status: fail");
      $finish;
    end
  end

  // Sends one request and waits until it is accepted.
  task automatic send_quat(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
    quat_bus.valid  <= 1'b1;
    quat_bus.quat_x <= qx;
    quat_bus.quat_y <= qy;
    quat_bus.quat_z <= qz;
    quat_bus.quat_w <= qw;
    do @(posedge clk_i); while (!quat_bus.ready);
    angle_board.note_request(qx, qy, qz, qw);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      quat_bus.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random component, biased to extremes now and then.
  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0: return comp_t'(16'sh7FFF);
      1: return comp_t'(16'sh8000);
      2: return '0;
      default: return comp_t'($urandom());
    endcase
  endfunction

  // Roughly normalised quaternion from random components.
  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = $itor($signed($urandom())) / 2147483648.0;
    b = $itor($signed($urandom())) / 2147483648.0;
    c = $itor($signed($urandom())) / 2147483648.0;
    d = $itor($signed($urandom())) / 2147483648.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
    send_quat(comp_t'($rtoi(a / n * 32767.0)), comp_t'($rtoi(b / n * 32767.0)),
              comp_t'($rtoi(c / n * 32767.0)), comp_t'($rtoi(d / n * 32767.0)));
  endtask

  initial begin
    int burst;
    int drain;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero quaternion, identity, axis rotations, extremes and clamping.
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sh8000);
    send_quat(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sh7FFF, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sh7FFF, 16'sd0);
    send_quat(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sh8000, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sh8000, 16'sd0);
    send_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
    send_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170);
    send_quat(16'sd0, -16'sd23170, 16'sd0, 16'sd23170);
    send_quat(16'sd0, 16'sd0, 16'sd23170, 16'sd23170);
    send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_quat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_quat(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_quat(16'sd0, 16'sh7FFF, 16'sd0, 16'sh7FFF);
    send_quat(16'sd0, 16'sh8000, 16'sd0, 16'sh7FFF);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);

    // Random: mostly near-unit quaternions, the rest arbitrary components.
    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
        if ($urandom_range(0, 9) < 6)
          send_unit_quat();
        else
          send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
    end
    quat_bus.valid <= 1'b0;

    while (angle_board.pending.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < DRAIN_WAIT; drain++) @(posedge clk_i);

    $display("Converted %0d quaternions, %0d with a saturated roll argument.",
             results_seen, clamped_seen);
    if (angle_board.errors == 0 && angle_board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
